// ----- hw/rtl/wcw_pkg.sv -----
package wcw_pkg;

  localparam int CordicSteps = 16;
  localparam int CntW = 5;
  localparam int ModSteps = 5;
  localparam int ScaleCycles = 5;
  localparam int CfgAddrW = 4;

  localparam int TwoPiQ13 = 51472;
  localparam int PiQ13 = 25736;

  localparam int ZW = 34;
  localparam int CrdW = 35;
  localparam int MagW = 21;
  localparam int AccW = 60;

  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [24:0] InvKQ24 = 25'sd10188012;

  typedef enum logic {
    ACT_START,
    ACT_ADVANCE
  } action_t;

  typedef enum logic [1:0] {
    REG_ANGLE_GAIN,
    REG_INIT_STEP_X,
    REG_INIT_STEP_Y
  } reg_idx_t;

  typedef enum logic {
    OSEL_ORIGIN,
    OSEL_VERTEX
  } out_sel_t;

  typedef struct packed {
    logic [15:0]        angle_gain;
    logic signed [31:0] init_step_x;
    logic signed [31:0] init_step_y;
  } cfg_t;

  typedef struct packed {
    logic            gain_mul;
    logic            angle;
    logic            mod_step;
    logic            wrap;
    logic            quad;
    logic            rot;
    logic            scale_mul;
    logic            step_upd;
    logic            pos_upd;
    logic            out_load;
    out_sel_t        out_sel;
    logic [CntW-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [CntW-1:0] idx);
    case (idx)
      5'd0:    return 34'sd843314856;
      5'd1:    return 34'sd497837829;
      5'd2:    return 34'sd263043836;
      5'd3:    return 34'sd133525158;
      5'd4:    return 34'sd67021686;
      5'd5:    return 34'sd33543515;
      5'd6:    return 34'sd16775850;
      5'd7:    return 34'sd8388437;
      5'd8:    return 34'sd4194282;
      5'd9:    return 34'sd2097149;
      5'd10:   return 34'sd1048575;
      5'd11:   return 34'sd524287;
      5'd12:   return 34'sd262143;
      5'd13:   return 34'sd131071;
      5'd14:   return 34'sd65535;
      5'd15:   return 34'sd32767;
      5'd16:   return 34'sd16383;
      5'd17:   return 34'sd8191;
      5'd18:   return 34'sd4095;
      5'd19:   return 34'sd2047;
      5'd20:   return 34'sd1023;
      5'd21:   return 34'sd511;
      5'd22:   return 34'sd255;
      5'd23:   return 34'sd127;
      5'd24:   return 34'sd63;
      5'd25:   return 34'sd31;
      5'd26:   return 34'sd15;
      5'd27:   return 34'sd7;
      5'd28:   return 34'sd3;
      5'd29:   return 34'sd1;
      default: return '0;
    endcase
  endfunction

  // two pi scaled down by one binary place per step of the remainder loop
  function automatic logic [MagW-1:0] mod_div(input logic [CntW-1:0] idx);
    return MagW'(TwoPiQ13 << (ModSteps - 1 - int'(idx)));
  endfunction

endpackage

// ----- hw/rtl/wcw_in_if.sv -----
interface wcw_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] normal_sample;

  modport source(output valid, action, normal_sample, input ready);
  modport sink(input valid, action, normal_sample, output ready);
endinterface

// ----- hw/rtl/wcw_out_if.sv -----
interface wcw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic               last_of_run;

  modport source(output valid, vertex_x, vertex_y, last_of_run, input ready);
  modport sink(input valid, vertex_x, vertex_y, last_of_run, output ready);
endinterface

// ----- hw/rtl/wcw_cfg.sv -----
module wcw_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wcw_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output wcw_pkg::cfg_t               cfg
);

  wcw_pkg::cfg_t    cfg_r;
  wcw_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = wcw_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_gain  <= 16'd4096;
      cfg_r.init_step_x <= 32'sd65536;
      cfg_r.init_step_y <= 32'sd0;
    end else if (wr_en) begin
      case (idx)
        wcw_pkg::REG_ANGLE_GAIN:  cfg_r.angle_gain  <= pwdata[15:0];
        wcw_pkg::REG_INIT_STEP_X: cfg_r.init_step_x <= signed'(pwdata);
        wcw_pkg::REG_INIT_STEP_Y: cfg_r.init_step_y <= signed'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wcw_pkg::REG_ANGLE_GAIN:  prdata = {16'd0, cfg_r.angle_gain};
      wcw_pkg::REG_INIT_STEP_X: prdata = cfg_r.init_step_x;
      wcw_pkg::REG_INIT_STEP_Y: prdata = cfg_r.init_step_y;
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/wcw_ctrl.sv -----
module wcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  wcw_pkg::dp_sts_t  sts,
  output wcw_pkg::dp_cmd_t  cmd
);

  localparam logic [wcw_pkg::CntW-1:0] ModLast   = wcw_pkg::CntW'(wcw_pkg::ModSteps - 1);
  localparam logic [wcw_pkg::CntW-1:0] RotLast   = wcw_pkg::CntW'(wcw_pkg::CordicSteps - 1);
  localparam logic [wcw_pkg::CntW-1:0] ScaleLast = wcw_pkg::CntW'(wcw_pkg::ScaleCycles - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_MOD,
    ST_WRAP,
    ST_QUAD,
    ST_ROT,
    ST_SCALE,
    ST_STEP,
    ST_POS,
    ST_EMIT,
    ST_ORIGIN,
    ST_INIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [wcw_pkg::CntW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == wcw_pkg::ACT_ADVANCE) begin
            cmd.gain_mul = 1'b1;
            state_nxt    = ST_ANGLE;
          end else begin
            state_nxt = ST_ORIGIN;
          end
        end
      end
      ST_ANGLE: begin
        cmd.angle = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt_r == ModLast) begin
          cnt_nxt   = '0;
          state_nxt = ST_WRAP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = ST_QUAD;
      end
      ST_QUAD: begin
        cmd.quad  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (cnt_r == RotLast) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale_mul = (cnt_r != ScaleLast);
        if (cnt_r == ScaleLast) begin
          cnt_nxt   = '0;
          state_nxt = ST_STEP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_STEP: begin
        cmd.step_upd = 1'b1;
        state_nxt    = ST_POS;
      end
      ST_POS: begin
        cmd.pos_upd = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = wcw_pkg::OSEL_VERTEX;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ORIGIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = wcw_pkg::OSEL_ORIGIN;
          state_nxt    = ST_INIT;
        end
      end
      ST_INIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = wcw_pkg::OSEL_VERTEX;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/wcw_dp.sv -----
module wcw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  wcw_pkg::cfg_t      cfg,
  input  wcw_pkg::dp_cmd_t   cmd,
  output wcw_pkg::dp_sts_t   sts,
  input  logic signed [15:0] in_sample,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic               out_last
);

  localparam int ZW   = wcw_pkg::ZW;
  localparam int CrdW = wcw_pkg::CrdW;
  localparam int MagW = wcw_pkg::MagW;
  localparam int AccW = wcw_pkg::AccW;
  localparam logic signed [21:0] Pi22    = 22'(wcw_pkg::PiQ13);
  localparam logic signed [21:0] TwoPi22 = 22'(wcw_pkg::TwoPiQ13);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // state and control
  logic signed [31:0] step_x_r, step_y_r, pos_x_r, pos_y_r;
  logic               out_vld_r;
  logic               pv_r;

  // payload
  logic signed [32:0]     prod_r;
  logic [MagW-1:0]        mag_r;
  logic                   neg_r;
  logic signed [15:0]     ang_r;
  logic signed [CrdW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0]   cz_r;
  logic signed [43:0]     sp_r;
  logic [1:0]             tag_r;
  logic signed [AccW-1:0] acc_x_r, acc_y_r;
  logic signed [31:0]     out_x_r, out_y_r;
  logic                   out_last_r;

  // gain multiply and angle rounding
  logic signed [16:0] gain_s;
  logic signed [32:0] gain_prod;
  logic signed [33:0] ang_sum;
  logic signed [21:0] ang22;
  logic [21:0]        ang_abs;

  assign gain_s    = signed'({1'b0, cfg.angle_gain});
  assign gain_prod = gain_s * in_sample;
  assign ang_sum   = 34'(prod_r) + 34'sd1024;
  assign ang22     = ang_sum[32:11];
  assign ang_abs   = ang22[21] ? 22'(-ang22) : 22'(ang22);

  // remainder step
  logic [MagW-1:0] div_c;
  assign div_c = wcw_pkg::mod_div(cmd.cnt);

  // wrap into minus pi to pi
  logic signed [21:0] rem, wrapped;
  assign rem = neg_r ? -signed'({1'b0, mag_r}) : signed'({1'b0, mag_r});

  always_comb begin
    if (rem >= Pi22) begin
      wrapped = rem - TwoPi22;
    end else if (rem < -Pi22) begin
      wrapped = rem + TwoPi22;
    end else begin
      wrapped = rem;
    end
  end

  // quadrant fold
  logic signed [CrdW-1:0] qx, qy, sx, sy;
  logic signed [ZW-1:0]   qz, z0;

  assign sx = CrdW'(step_x_r);
  assign sy = CrdW'(step_y_r);
  assign z0 = signed'({ang_r[15], ang_r, 17'd0});

  always_comb begin
    if (z0 > wcw_pkg::HalfPiQ30) begin
      qx = -sy;
      qy = sx;
      qz = z0 - wcw_pkg::HalfPiQ30;
    end else if (z0 < -wcw_pkg::HalfPiQ30) begin
      qx = sy;
      qy = -sx;
      qz = z0 + wcw_pkg::HalfPiQ30;
    end else begin
      qx = sx;
      qy = sy;
      qz = z0;
    end
  end

  // cordic iteration
  logic signed [CrdW-1:0] dx, dy;
  logic signed [ZW-1:0]   at;

  assign dx = cy_r >>> cmd.cnt;
  assign dy = cx_r >>> cmd.cnt;
  assign at = wcw_pkg::atan_q30(cmd.cnt);

  // gain correction, coordinates split into low and high halves
  logic signed [18:0]     op;
  logic signed [43:0]     sp_c;
  logic signed [AccW-1:0] sp_ext;

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    op = signed'({1'b0, cx_r[17:0]});
      2'd1:    op = 19'(signed'(cx_r[CrdW-1:18]));
      2'd2:    op = signed'({1'b0, cy_r[17:0]});
      default: op = 19'(signed'(cy_r[CrdW-1:18]));
    endcase
  end

  assign sp_c   = op * wcw_pkg::InvKQ24;
  assign sp_ext = AccW'(sp_r);

  logic signed [AccW-1:0] rnd_x, rnd_y;
  assign rnd_x = acc_x_r + AccW'(64'sd8388608);
  assign rnd_y = acc_y_r + AccW'(64'sd8388608);

  assign sts.out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r  <= '0;
      step_y_r  <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      out_vld_r <= 1'b0;
      pv_r      <= 1'b0;
    end else begin
      pv_r <= cmd.scale_mul;
      if (cmd.step_upd) begin
        step_x_r <= sat32(rnd_x[59:24]);
        step_y_r <= sat32(rnd_y[59:24]);
      end
      if (cmd.pos_upd) begin
        pos_x_r <= sat32(36'(pos_x_r) + 36'(step_x_r));
        pos_y_r <= sat32(36'(pos_y_r) + 36'(step_y_r));
      end
      if (cmd.out_load && cmd.out_sel == wcw_pkg::OSEL_ORIGIN) begin
        step_x_r <= cfg.init_step_x;
        step_y_r <= cfg.init_step_y;
        pos_x_r  <= cfg.init_step_x;
        pos_y_r  <= cfg.init_step_y;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain_mul) begin
      prod_r <= gain_prod;
    end
    if (cmd.angle) begin
      neg_r <= ang22[21];
      mag_r <= ang_abs[MagW-1:0];
    end
    if (cmd.mod_step && mag_r >= div_c) begin
      mag_r <= mag_r - div_c;
    end
    if (cmd.wrap) begin
      ang_r <= wrapped[15:0];
    end
    if (cmd.quad) begin
      cx_r <= qx;
      cy_r <= qy;
      cz_r <= qz;
    end
    if (cmd.rot) begin
      if (cz_r >= 0) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.scale_mul) begin
      sp_r  <= sp_c;
      tag_r <= cmd.cnt[1:0];
    end
    if (pv_r) begin
      case (tag_r)
        2'd0:    acc_x_r <= sp_ext;
        2'd1:    acc_x_r <= acc_x_r + (sp_ext <<< 18);
        2'd2:    acc_y_r <= sp_ext;
        default: acc_y_r <= acc_y_r + (sp_ext <<< 18);
      endcase
    end
    if (cmd.out_load) begin
      if (cmd.out_sel == wcw_pkg::OSEL_ORIGIN) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_last_r <= 1'b0;
      end else begin
        out_x_r    <= pos_x_r;
        out_y_r    <= pos_y_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid    = out_vld_r;
  assign out_vertex_x = out_x_r;
  assign out_vertex_y = out_y_r;
  assign out_last     = out_last_r;

endmodule

// ----- hw/rtl/wormlike_chain_walk_2d.sv -----
// advance, one item at a time: gain multiply, angle rounding, remainder, wrap,
//   quadrant fold, cordic, gain correction, step and position update, then the output load
// start: two results, origin then initial vertex, each loaded into a free output register
// the output register holds a finished result while the next item is taken
// rst_n is synchronous, active low: walk state clears to zero, registers take their defaults
module wormlike_chain_walk_2d (
  input  logic                         clk,
  input  logic                         rst_n,
  wcw_in_if.sink                       in_ch,
  wcw_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wcw_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  wcw_pkg::cfg_t     cfg;
  wcw_pkg::dp_cmd_t  cmd;
  wcw_pkg::dp_sts_t  sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  wcw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wcw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_ch.normal_sample),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_vertex_x (out_ch.vertex_x),
    .out_vertex_y (out_ch.vertex_y),
    .out_last     (out_ch.last_of_run)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after a transfer");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  a_origin_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_run |-> out_ch.vertex_x == 32'sd0 && out_ch.vertex_y == 32'sd0)
    else $error("non-final result is not the origin");

  a_mul_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gain_mul |-> in_ch.valid && in_ch.ready && in_ch.action)
    else $error("gain multiply without an advance transfer");
`endif

endmodule
